[src/assert_macros.svh]
// Assertion macros shared by the resonator RTL.
// Included by modules that check their own sequencing; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/scr_pkg.sv]
// Package for the stereo complex resonator: widths, word types, control codes
// and saturation helpers. Used by scr_mac and stereo_complex_resonator_top.
package scr_pkg;

  // Number formats.
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int STATE_BITS     = 40;
  localparam int ALIGN_SHIFT    = 7;
  localparam int OUT_SHIFT      = COEF_FRAC_BITS + ALIGN_SHIFT;

  // Register widths.
  localparam int COEF_BITS   = COEF_FRAC_BITS + 2;
  localparam int RADIUS_BITS = COEF_FRAC_BITS + 1;
  localparam int GAIN_BITS   = COEF_FRAC_BITS + 2;
  localparam int CFG_DATA_W  = COEF_FRAC_BITS + 2;
  localparam int CFG_IDX_W   = 3;

  // The state word is split in two halves for the narrow multiplier.
  localparam int STATE_LO_BITS = STATE_BITS / 2;
  localparam int STATE_HI_BITS = STATE_BITS - STATE_LO_BITS;

  // Multiplier and accumulator widths.
  localparam int MUL_A_W0 = (SAMPLE_BITS > STATE_LO_BITS + 1) ? SAMPLE_BITS : STATE_LO_BITS + 1;
  localparam int MUL_A_W  = (MUL_A_W0 > STATE_HI_BITS) ? MUL_A_W0 : STATE_HI_BITS;
  localparam int MUL_B_W  = COEF_FRAC_BITS + 3;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = STATE_BITS + MUL_B_W + 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLE_RE     = 3'd0,
    CFG_POLE_IM     = 3'd1,
    CFG_POLE_RADIUS = 3'd2,
    CFG_ADD_MODE    = 3'd3,
    CFG_MIX_GAIN    = 3'd4
  } cfg_idx_e;

  // Alignment of a product before it enters the accumulator.
  typedef enum logic [1:0] {
    SH_NONE  = 2'd0,
    SH_ALIGN = 2'd1,
    SH_SPLIT = 2'd2,
    SH_OUT   = 2'd3
  } shift_e;

  // Rounding offset loaded when the accumulator starts a new sum.
  typedef enum logic [1:0] {
    RND_COEF  = 2'd0,
    RND_ALIGN = 2'd1,
    RND_OUT   = 2'd2
  } rnd_e;

  // Control word from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic   en;
    logic   clear;
    logic   negate;
    shift_e sh;
    rnd_e   rnd;
  } mac_ctrl_t;

  // Input word.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
    logic signed [SAMPLE_BITS-1:0] prior_left;
    logic signed [SAMPLE_BITS-1:0] prior_right;
    logic                          block_end;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          block_end_out;
  } out_word_t;

  // Clamp an accumulator value to the state range.
  function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[STATE_BITS-1:0];
    end else if (v < lo) begin
      return lo[STATE_BITS-1:0];
    end
    return v[STATE_BITS-1:0];
  endfunction

  // Clamp an accumulator value to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

[src/scr_mac.sv]
// Shared multiply-accumulate unit of the stereo complex resonator.
// Depends on scr_pkg for widths and the mac_ctrl_t control word.
module scr_mac (
  input  logic                                clk_i,
  input  scr_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [scr_pkg::MUL_A_W-1:0]  op_a_i,
  input  logic signed [scr_pkg::MUL_B_W-1:0]  op_b_i,
  output logic signed [scr_pkg::ACC_W-1:0]    acc_o
);

  localparam int AccW  = scr_pkg::ACC_W;
  localparam int ProdW = scr_pkg::PROD_W;

  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  term;
  logic signed [AccW-1:0]  base;
  logic signed [AccW-1:0]  acc_d;
  logic signed [AccW-1:0]  acc_q;

  // One signed product per cycle, sign-extended to the accumulator width.
  assign prod     = op_a_i * op_b_i;
  assign prod_ext = AccW'(prod);

  // Align the product and apply the sign of the term.
  always_comb begin
    case (ctrl_i.sh)
      scr_pkg::SH_NONE:  term = prod_ext;
      scr_pkg::SH_ALIGN: term = prod_ext <<< scr_pkg::ALIGN_SHIFT;
      scr_pkg::SH_SPLIT: term = prod_ext <<< scr_pkg::STATE_LO_BITS;
      scr_pkg::SH_OUT:   term = prod_ext <<< scr_pkg::OUT_SHIFT;
      default:           term = prod_ext;
    endcase
    if (ctrl_i.negate) begin
      term = -term;
    end
  end

  // A new sum starts from its half-LSB rounding offset.
  always_comb begin
    if (ctrl_i.clear) begin
      case (ctrl_i.rnd)
        scr_pkg::RND_COEF:  base = AccW'(1) <<< (scr_pkg::COEF_FRAC_BITS - 1);
        scr_pkg::RND_ALIGN: base = AccW'(1) <<< (scr_pkg::ALIGN_SHIFT - 1);
        scr_pkg::RND_OUT:   base = AccW'(1) <<< (scr_pkg::OUT_SHIFT - 1);
        default:            base = '0;
      endcase
    end else begin
      base = acc_q;
    end
    acc_d = base + term;
  end

  // Accumulator register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

[src/stereo_complex_resonator_top.sv]
// Stereo complex one-pole resonator: the top level with sequencer, state and handshakes.
// Depends on scr_pkg, scr_mac and assert_macros.svh.
//
// An accepted word runs through thirteen sequencer steps per channel on the single
// 24 x 19 bit multiply-accumulate unit (twelve products and one capture), then is loaded
// into the output register. The shared multiplier sets the step count:
// the 40-bit state is fed to it in two halves, so each complex update takes nine products
// and the output scaling three more. in_stall_o is high from acceptance until the result
// moves into the output register; a finished word waits there while the next input word
// is taken. Configuration writes take effect at once and are meant for idle periods.
module stereo_complex_resonator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [scr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [scr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  scr_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output scr_pkg::out_word_t                out_word_o
);

  `include "assert_macros.svh"

  localparam int SampW = scr_pkg::SAMPLE_BITS;
  localparam int StW   = scr_pkg::STATE_BITS;
  localparam int LoW   = scr_pkg::STATE_LO_BITS;
  localparam int AW    = scr_pkg::MUL_A_W;
  localparam int BW    = scr_pkg::MUL_B_W;
  localparam int AccW  = scr_pkg::ACC_W;
  localparam int FracW = scr_pkg::COEF_FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_PUSH = 3'b100
  } state_e;

  // Sequencer steps of one channel.
  typedef enum logic [3:0] {
    SP_SR0 = 4'd0,
    SP_SR1 = 4'd1,
    SP_SR2 = 4'd2,
    SP_SR3 = 4'd3,
    SP_SR4 = 4'd4,
    SP_TI0 = 4'd5,
    SP_TI1 = 4'd6,
    SP_TI2 = 4'd7,
    SP_TI3 = 4'd8,
    SP_OU0 = 4'd9,
    SP_OU1 = 4'd10,
    SP_OU2 = 4'd11,
    SP_OU3 = 4'd12
  } step_e;

  // Configuration registers.
  logic signed [scr_pkg::COEF_BITS-1:0]   pole_re_q;
  logic signed [scr_pkg::COEF_BITS-1:0]   pole_im_q;
  logic        [scr_pkg::RADIUS_BITS-1:0] pole_radius_q;
  logic                                   add_mode_q;
  logic        [scr_pkg::GAIN_BITS-1:0]   mix_gain_q;

  // Control state.
  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   ch_q, ch_d;
  logic   out_valid_q, out_valid_d;

  // Filter state and payload registers.
  logic signed [StW-1:0]  s_st_q [2];
  logic signed [StW-1:0]  t_st_q [2];
  logic signed [StW-1:0]  s_new_q;
  logic signed [SampW-1:0] y_q [2];
  scr_pkg::in_word_t      in_q;
  scr_pkg::out_word_t     out_word_q;

  // Datapath signals.
  scr_pkg::mac_ctrl_t     mac_ctrl;
  logic signed [AW-1:0]   op_a;
  logic signed [BW-1:0]   op_b;
  logic signed [AccW-1:0] acc;
  logic signed [StW-1:0]  s_cur;
  logic signed [StW-1:0]  t_cur;
  logic signed [AW-1:0]   s_lo_a, s_hi_a, t_lo_a, t_hi_a, n_lo_a, n_hi_a;
  logic signed [AW-1:0]   x_a, prior_a;
  logic signed [BW-1:0]   re_b, im_b, g_b, gout_b, unit_b;
  logic signed [StW-1:0]  acc_state;
  logic signed [SampW-1:0] y_ch;
  logic                   in_take;
  logic                   out_take;
  logic                   out_load;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_re_q     <= '0;
      pole_im_q     <= '0;
      pole_radius_q <= '0;
      add_mode_q    <= 1'b0;
      mix_gain_q    <= scr_pkg::GAIN_BITS'(1) << FracW;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        scr_pkg::CFG_POLE_RE:     pole_re_q     <= cfg_data_i[scr_pkg::COEF_BITS-1:0];
        scr_pkg::CFG_POLE_IM:     pole_im_q     <= cfg_data_i[scr_pkg::COEF_BITS-1:0];
        scr_pkg::CFG_POLE_RADIUS: pole_radius_q <= cfg_data_i[scr_pkg::RADIUS_BITS-1:0];
        scr_pkg::CFG_ADD_MODE:    add_mode_q    <= cfg_data_i[0];
        scr_pkg::CFG_MIX_GAIN:    mix_gain_q    <= cfg_data_i[scr_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_load    = (state_q == ST_PUSH) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Operand halves of the current channel's state and of the freshly computed real part.
  assign s_cur  = s_st_q[ch_q];
  assign t_cur  = t_st_q[ch_q];
  assign s_lo_a = signed'(AW'(s_cur[LoW-1:0]));
  assign s_hi_a = AW'(signed'(s_cur[StW-1:LoW]));
  assign t_lo_a = signed'(AW'(t_cur[LoW-1:0]));
  assign t_hi_a = AW'(signed'(t_cur[StW-1:LoW]));
  assign n_lo_a = signed'(AW'(s_new_q[LoW-1:0]));
  assign n_hi_a = AW'(signed'(s_new_q[StW-1:LoW]));
  assign x_a     = AW'(ch_q ? in_q.in_right : in_q.in_left);
  assign prior_a = AW'(ch_q ? in_q.prior_right : in_q.prior_left);

  // Coefficient operands; the input gain is one minus the radius, unclamped.
  assign re_b   = BW'(pole_re_q);
  assign im_b   = BW'(pole_im_q);
  assign g_b    = signed'((BW'(1) << FracW) - BW'(pole_radius_q));
  assign unit_b = BW'(1);
  assign gout_b = add_mode_q ? signed'(BW'(mix_gain_q)) : unit_b;

  // Rounded and saturated views of the accumulator.
  assign acc_state = scr_pkg::sat_state(acc >>> FracW);
  assign y_ch = add_mode_q ? scr_pkg::sat_sample(acc >>> scr_pkg::OUT_SHIFT)
                           : scr_pkg::sat_sample(acc >>> scr_pkg::ALIGN_SHIFT);

  // Step decoder: operands and accumulator control for each sequencer step.
  always_comb begin
    mac_ctrl.en     = (state_q == ST_CALC) && (step_q != SP_OU3);
    mac_ctrl.clear  = 1'b0;
    mac_ctrl.negate = 1'b0;
    mac_ctrl.sh     = scr_pkg::SH_NONE;
    mac_ctrl.rnd    = scr_pkg::RND_COEF;
    op_a            = s_lo_a;
    op_b            = re_b;
    case (step_q)
      // New real part: s*re - t*im + x*g.
      SP_SR0: begin
        mac_ctrl.clear = 1'b1;
      end
      SP_SR1: begin
        op_a        = s_hi_a;
        mac_ctrl.sh = scr_pkg::SH_SPLIT;
      end
      SP_SR2: begin
        op_a            = t_lo_a;
        op_b            = im_b;
        mac_ctrl.negate = 1'b1;
      end
      SP_SR3: begin
        op_a            = t_hi_a;
        op_b            = im_b;
        mac_ctrl.negate = 1'b1;
        mac_ctrl.sh     = scr_pkg::SH_SPLIT;
      end
      SP_SR4: begin
        op_a        = x_a;
        op_b        = g_b;
        mac_ctrl.sh = scr_pkg::SH_ALIGN;
      end
      // New imaginary part: t*re + s*im.
      SP_TI0: begin
        op_a           = t_lo_a;
        mac_ctrl.clear = 1'b1;
      end
      SP_TI1: begin
        op_a        = t_hi_a;
        mac_ctrl.sh = scr_pkg::SH_SPLIT;
      end
      SP_TI2: begin
        op_a = s_lo_a;
        op_b = im_b;
      end
      SP_TI3: begin
        op_a        = s_hi_a;
        op_b        = im_b;
        mac_ctrl.sh = scr_pkg::SH_SPLIT;
      end
      // Output: new real part times the gain, plus the prior value in add mode.
      SP_OU0: begin
        op_a           = n_lo_a;
        op_b           = gout_b;
        mac_ctrl.clear = 1'b1;
        mac_ctrl.rnd   = add_mode_q ? scr_pkg::RND_OUT : scr_pkg::RND_ALIGN;
      end
      SP_OU1: begin
        op_a        = n_hi_a;
        op_b        = gout_b;
        mac_ctrl.sh = scr_pkg::SH_SPLIT;
      end
      SP_OU2: begin
        op_a        = prior_a;
        op_b        = add_mode_q ? unit_b : '0;
        mac_ctrl.sh = scr_pkg::SH_OUT;
      end
      SP_OU3: begin
        mac_ctrl.en = 1'b0;
      end
      default: begin
        mac_ctrl.en = 1'b0;
      end
    endcase
  end

  scr_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .acc_o  (acc)
  );

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ch_d        = ch_q;
    out_valid_d = out_load || (out_valid_q && !out_take);
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = ST_CALC;
          step_d  = SP_SR0;
          ch_d    = 1'b0;
        end
      end
      ST_CALC: begin
        if (step_q == SP_OU3) begin
          step_d = SP_SR0;
          if (!ch_q) begin
            ch_d = 1'b1;
          end else begin
            state_d = ST_PUSH;
          end
        end else begin
          step_d = step_e'(step_q + 4'd1);
        end
      end
      ST_PUSH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and filter state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= SP_SR0;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        s_st_q[i] <= '0;
        t_st_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      if ((state_q == ST_CALC) && (step_q == SP_OU0)) begin
        s_st_q[ch_q] <= s_new_q;
        t_st_q[ch_q] <= acc_state;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
    if ((state_q == ST_CALC) && (step_q == SP_TI0)) begin
      s_new_q <= acc_state;
    end
    if ((state_q == ST_CALC) && (step_q == SP_OU3)) begin
      y_q[ch_q] <= y_ch;
    end
    if (out_load) begin
      out_word_q.out_left      <= y_q[0];
      out_word_q.out_right     <= y_q[1];
      out_word_q.block_end_out <= in_q.block_end;
    end
  end

  // Checks on the sequencer.
  `SCR_ASSERT_NEXT(a_accept_starts, in_take,
    (state_q == ST_CALC) && (step_q == SP_SR0) && !ch_q, "accepted word did not start at step 0")
  `SCR_ASSERT_SAME(a_push_after_right, state_q == ST_PUSH, ch_q,
    "output push before the right channel finished")
  `SCR_ASSERT_NEXT(a_hold_stalled, (state_q == ST_PUSH) && out_valid_q && out_stall_i,
    (state_q == ST_PUSH) && out_valid_q, "stalled output word was overwritten")
  `SCR_ASSERT_SAME(a_valid_from_push, $rose(out_valid_q), $past(state_q == ST_PUSH),
    "output valid rose outside the push state")

endmodule
